### hdl/arfc_pkg.sv
`default_nettype none

package arfc_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_FAULT  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_REGION    = 3'd1,
    ST_WRITE_DENIED = 3'd2,
    ST_READ_PRESENT = 3'd3,
    ST_READ_DENIED  = 3'd4,
    ST_BAD_RANGE    = 3'd5,
    ST_FULL         = 3'd6
  } status_t;

  // region flag bits
  localparam int RIGHT_READ_BIT  = 0;
  localparam int RIGHT_WRITE_BIT = 1;
  localparam int RIGHT_EXEC_BIT  = 2;

  // access code bits and the plain read of a present page
  localparam int              ACC_WRITE_BIT    = 1;
  localparam logic [1:0]      ACC_READ_PRESENT = 2'b01;

  // page permission bits
  localparam logic [2:0] PERM_WRITE = 3'h2;
  localparam logic [2:0] PERM_USER  = 3'h4;

  // one stored region
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] limit;
    logic [2:0]  rights;
  } arfc_entry_t;

  // outcome of the access check
  typedef struct packed {
    status_t    status;
    logic [2:0] perm;
  } arfc_verdict_t;

endpackage

`default_nettype wire

### hdl/address_region_table_fault_check.sv
`default_nettype none

// Sorted table of non-overlapping address regions with a page-fault check.
// Input: an item is transferred at a rising edge with start high and busy low.
// kind 0 inserts a region, 1 looks up a fault address, 2 clears the table.
// Output: one result per item, shown for one cycle with out_valid high; the
// receiver cannot stall, so the result is always taken in that cycle.
// Regions live in one memory with a registered read; lookup and
// insert scan it one entry per cycle from the lowest base upwards.
// Clear, unused kind and an empty or reversed insert give their result in the
// cycle after the transfer. An insert scans up to its sorted place p, then
// moves the used-p entries above it up one place at one entry per cycle and
// writes the new one.
// busy stays high while a lookup or insert scans or shifts; the next item may be
// transferred in the cycle in which the result is shown.
// Reset empties the table and zeroes the fault count; no memory sweep needed.
module address_region_table_fault_check #(
  parameter int MAX_REGIONS = 16,
  parameter int PAGE_SHIFT  = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_region_base,
  input  wire logic [31:0] in_region_limit,
  input  wire logic [2:0]  in_region_rights,
  input  wire logic [31:0] in_fault_address,
  input  wire logic [1:0]  in_access_code,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [3:0]       out_hit_index,
  output logic [31:0]      out_hit_base,
  output logic [31:0]      out_hit_limit,
  output logic [2:0]       out_hit_rights,
  output logic [31:0]      out_page_base,
  output logic [2:0]       out_page_perm,
  output logic [4:0]       out_entries_used,
  output logic [31:0]      out_faults_seen
);
  import arfc_pkg::*;

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [31:0] PAGE_MASK = ~((32'd1 << PAGE_SHIFT) - 32'd1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  kind_t         kind_r;
  logic [31:0]   base_r, limit_r, addr_r;
  logic [2:0]    rights_r;
  logic [1:0]    code_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [31:0]   faults_r, faults_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [CW-1:0] rd_tag_r, rd_tag_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [31:0]   prev_end_r, prev_end_nxt;
  logic          have_prev_r, have_prev_nxt;

  logic          accept;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  arfc_entry_t   mem_wdata, mem_rdata;
  arfc_verdict_t verdict;

  logic [CW-1:0] cnt_dec, tag_inc, ins_pos;
  logic          hit_ins, hit_flt, stop, exhausted, overlap;

  // result being formed
  logic          res_fire;
  status_t       res_status;
  logic [CW-1:0] res_index;
  logic [31:0]   res_base, res_limit, res_page;
  logic [2:0]    res_rights, res_perm;
  logic [31:0]   res_index_ext, res_used_ext;

  logic          out_valid_r;
  logic [2:0]    out_status_r, out_hit_rights_r, out_page_perm_r;
  logic [3:0]    out_hit_index_r;
  logic [31:0]   out_hit_base_r, out_hit_limit_r, out_page_base_r, out_faults_seen_r;
  logic [4:0]    out_entries_used_r;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  arfc_mem #(
    .DEPTH (MAX_REGIONS),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  arfc_check u_check (
    .rights  (mem_rdata.rights),
    .code    (code_r),
    .verdict (verdict)
  );

  // scan compares on the entry just read
  assign cnt_dec   = cnt_r - CW'(1);
  assign tag_inc   = rd_tag_r + CW'(1);
  assign hit_ins   = rd_vld_r && (mem_rdata.base > base_r);
  assign hit_flt   = rd_vld_r && (mem_rdata.base <= addr_r) && (addr_r < mem_rdata.limit);
  assign stop      = (kind_r == KIND_INSERT) ? hit_ins : hit_flt;
  assign exhausted = !rd_vld_r && (cnt_r == used_r);
  assign ins_pos   = stop ? rd_tag_r : used_r;
  assign overlap   = (have_prev_r && (prev_end_r > base_r)) ||
                     (stop && (limit_r > mem_rdata.base));

  // sequencer: scan, shift up, place
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    faults_nxt    = faults_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    prev_end_nxt  = prev_end_r;
    have_prev_nxt = have_prev_r;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r[IW-1:0];
    mem_we        = 1'b0;
    mem_waddr     = tag_inc[IW-1:0];
    mem_wdata     = mem_rdata;
    res_fire      = 1'b0;
    res_status    = ST_OK;
    res_index     = '0;
    res_base      = '0;
    res_limit     = '0;
    res_rights    = '0;
    res_page      = '0;
    res_perm      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt       = '0;
          have_prev_nxt = 1'b0;
          case (kind_t'(in_kind))
            KIND_INSERT: begin
              if (in_region_base >= in_region_limit) begin
                res_fire   = 1'b1;
                res_status = ST_BAD_RANGE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            KIND_FAULT: begin
              faults_nxt = faults_r + 32'd1;
              state_nxt  = S_SCAN;
            end
            KIND_CLEAR: begin
              used_nxt = '0;
              res_fire = 1'b1;
            end
            default: begin
              res_fire = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue the next read while the scan goes on
        if ((cnt_r < used_r) && !stop) begin
          mem_re  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
        // remember the last region that starts at or below the new base
        if ((kind_r == KIND_INSERT) && rd_vld_r && !hit_ins) begin
          prev_end_nxt  = mem_rdata.limit;
          have_prev_nxt = 1'b1;
        end
        if (stop || exhausted) begin
          state_nxt = S_IDLE;
          if (kind_r == KIND_FAULT) begin
            res_fire = 1'b1;
            if (stop) begin
              res_status = verdict.status;
              res_index  = rd_tag_r;
              res_base   = mem_rdata.base;
              res_limit  = mem_rdata.limit;
              res_rights = mem_rdata.rights;
              if (verdict.status == ST_OK) begin
                res_page = addr_r & PAGE_MASK;
                res_perm = verdict.perm;
              end
            end else begin
              res_status = ST_NO_REGION;
            end
          end else begin
            res_index = ins_pos;
            if (overlap) begin
              res_fire   = 1'b1;
              res_status = ST_BAD_RANGE;
            end else if (used_r == CW'(MAX_REGIONS)) begin
              res_fire   = 1'b1;
              res_status = ST_FULL;
            end else begin
              state_nxt = S_SHIFT;
              pos_nxt   = ins_pos;
              cnt_nxt   = used_r;
            end
          end
        end
      end

      S_SHIFT: begin
        // read downwards, write each entry one place up in the next cycle
        if (cnt_r > pos_r) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_dec[IW-1:0];
          cnt_nxt   = cnt_dec;
        end
        if (rd_vld_r) begin
          mem_we = 1'b1;
        end else if (cnt_r == pos_r) begin
          mem_we           = 1'b1;
          mem_waddr        = pos_r[IW-1:0];
          mem_wdata.base   = base_r;
          mem_wdata.limit  = limit_r;
          mem_wdata.rights = rights_r;
          used_nxt         = used_r + CW'(1);
          res_fire         = 1'b1;
          res_status       = ST_OK;
          res_index        = pos_r;
          res_base         = base_r;
          res_limit        = limit_r;
          res_rights       = rights_r;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_vld_nxt    = mem_re;
  assign rd_tag_nxt    = CW'(mem_raddr);
  assign res_index_ext = 32'(res_index);
  assign res_used_ext  = 32'(used_nxt);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      faults_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      faults_r    <= faults_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= res_fire;
    end
  end

  // item fields and scan bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= kind_t'(in_kind);
      base_r   <= in_region_base;
      limit_r  <= in_region_limit;
      rights_r <= in_region_rights;
      addr_r   <= in_fault_address;
      code_r   <= in_access_code;
    end
    cnt_r       <= cnt_nxt;
    rd_tag_r    <= rd_tag_nxt;
    pos_r       <= pos_nxt;
    prev_end_r  <= prev_end_nxt;
    have_prev_r <= have_prev_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_status_r       <= res_status;
      out_hit_index_r    <= res_index_ext[3:0];
      out_hit_base_r     <= res_base;
      out_hit_limit_r    <= res_limit;
      out_hit_rights_r   <= res_rights;
      out_page_base_r    <= res_page;
      out_page_perm_r    <= res_perm;
      out_entries_used_r <= res_used_ext[4:0];
      out_faults_seen_r  <= faults_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_hit_index    = out_hit_index_r;
  assign out_hit_base     = out_hit_base_r;
  assign out_hit_limit    = out_hit_limit_r;
  assign out_hit_rights   = out_hit_rights_r;
  assign out_page_base    = out_page_base_r;
  assign out_page_perm    = out_page_perm_r;
  assign out_entries_used = out_entries_used_r;
  assign out_faults_seen  = out_faults_seen_r;

endmodule

`default_nettype wire

### hdl/arfc_mem.sv
`default_nettype none

module arfc_mem #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [IW-1:0]        waddr,
  input  wire arfc_pkg::arfc_entry_t wdata,
  input  wire logic                 re,
  input  wire logic [IW-1:0]        raddr,
  output arfc_pkg::arfc_entry_t     rdata
);
  import arfc_pkg::*;

  arfc_entry_t mem [DEPTH];
  arfc_entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/arfc_check.sv
`default_nettype none

module arfc_check (
  input  wire logic [2:0]          rights,
  input  wire logic [1:0]          code,
  output arfc_pkg::arfc_verdict_t  verdict
);
  import arfc_pkg::*;

  // classify the access against the region flags
  always_comb begin
    verdict.perm = PERM_USER | (rights[RIGHT_WRITE_BIT] ? PERM_WRITE : 3'h0);
    if (code[ACC_WRITE_BIT]) begin
      verdict.status = rights[RIGHT_WRITE_BIT] ? ST_OK : ST_WRITE_DENIED;
    end else if (code == ACC_READ_PRESENT) begin
      verdict.status = ST_READ_PRESENT;
    end else if (rights[RIGHT_READ_BIT] || rights[RIGHT_EXEC_BIT]) begin
      verdict.status = ST_OK;
    end else begin
      verdict.status = ST_READ_DENIED;
    end
  end

endmodule

`default_nettype wire
